// File: hdl/mmf_pkg.sv
// mmf_pkg: frame geometry, pixel type, result control struct and compare helper
// shared by the min/max filter cells, the reduction tree and the top level
// no dependencies
package mmf_pkg;

    localparam int WIDTH  = 176;
    localparam int HEIGHT = 144;

    localparam int COL_W = $clog2(WIDTH);
    localparam int ROW_W = $clog2(HEIGHT + 2);
    localparam int PIX_W = 8;
    localparam int POS_W = 8;

    localparam logic MODE_MIN = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [POS_W-1:0] pos_t;

    // which window entries take part, and where the result sits
    typedef struct packed {
        logic [2:0] row_en;
        logic [2:0] col_en;
        pos_t       row;
        pos_t       col;
        logic       last;
    } res_ctl_t;

    function automatic pix_t pick(input pix_t a, input pix_t b, input logic mode);
        pix_t r;
        if (mode == MODE_MAX)
        begin
            r = (a > b) ? a : b;
        end
        else
        begin
            r = (a < b) ? a : b;
        end
        return r;
    endfunction

endpackage

// File: hdl/mmf_cell.sv
// mmf_cell: one 8-bit storage cell of a shift chain, passes its pixel on per item
// used for the line stores and the 3x3 window; depends on mmf_pkg
module mmf_cell (
    input  logic        clk,
    input  logic        en,
    input  mmf_pkg::pix_t d,
    output mmf_pkg::pix_t q
);
    import mmf_pkg::*;

    pix_t pix_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= d;
        end
    end

    assign q = pix_reg;

endmodule

// File: hdl/mmf_reduce.sv
// mmf_reduce: masked nine-way minimum or maximum over the 3x3 window
// masked entries are padded so they never win; depends on mmf_pkg
module mmf_reduce (
    input  logic [8:0][mmf_pkg::PIX_W-1:0] win,
    input  logic [8:0]                     en,
    input  logic                           mode,
    output mmf_pkg::pix_t                  value
);
    import mmf_pkg::*;

    pix_t pad;
    pix_t padded [9];
    pix_t lv1 [4];
    pix_t lv2 [2];
    pix_t lv3;

    always_comb
    begin
        pad = (mode == MODE_MAX) ? '0 : '1;
        for (int i = 0; i < 9; i++)
        begin
            padded[i] = en[i] ? pix_t'(win[i]) : pad;
        end
        for (int i = 0; i < 4; i++)
        begin
            lv1[i] = pick(padded[2*i], padded[2*i+1], mode);
        end
        lv2[0] = pick(lv1[0], lv1[1], mode);
        lv2[1] = pick(lv1[2], lv1[3], mode);
        lv3    = pick(lv2[0], lv2[1], mode);
        value  = pick(lv3, padded[8], mode);
    end

endmodule

// File: hdl/min_max_filter_3x3_top.sv
// min_max_filter_3x3_top: 3x3 erosion / dilation over a raster pixel stream
// throughput: one item per cycle unless m_axis_tready stalls the output; a result passes the
// s1 and output registers after the item that completes its neighborhood, WIDTH+1 items after its own pixel
// the rate is set by the cell chains, which shift once per accepted item
// reset: async active low clears position, pipeline valids and mode;
// line store and window cells are not reset
module min_max_filter_3x3_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // pixel[7:0]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [23:0]               m_axis_tdata,   // value[7:0], out_row[15:8], out_col[23:16]
    output logic                      m_axis_tlast    // frame_last
);
    import mmf_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             mode_reg;
    logic             s1_valid_reg;
    res_ctl_t         s1_ctl_reg;
    logic             out_valid_reg;
    res_ctl_t         out_ctl_reg;
    pix_t             out_value_reg;

    logic             advance;
    logic             in_acc;
    logic             res_hit;
    res_ctl_t         res_ctl;
    logic [ROW_W-1:0] row_m1, row_m2;
    logic [COL_W-1:0] col_m1;
    pix_t             new_pix;

    pix_t mid_q [WIDTH];
    pix_t up_q  [WIDTH];
    pix_t win_q [9];
    pix_t new_col [3];

    logic [8:0][PIX_W-1:0] win_flat;
    logic [8:0]            win_en;
    pix_t                  red_value;

    // handshake
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || advance;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // position counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (row_reg == ROW_W'(HEIGHT + 1))
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_reg == COL_W'(WIDTH - 1))
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MIN;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    // which result, if any, the item completes (in terms of the shifted window)
    assign row_m1 = row_reg - ROW_W'(1);
    assign row_m2 = row_reg - ROW_W'(2);
    assign col_m1 = col_reg - COL_W'(1);

    always_comb
    begin
        res_hit        = 1'b0;
        res_ctl.row_en = '0;
        res_ctl.col_en = '0;
        res_ctl.row    = '0;
        res_ctl.col    = '0;
        res_ctl.last   = 1'b0;
        if (col_reg == '0)
        begin
            if (row_reg >= ROW_W'(2))
            begin
                // last column of the row two above
                res_hit           = 1'b1;
                res_ctl.row_en[0] = (row_reg != ROW_W'(2));
                res_ctl.row_en[1] = 1'b1;
                res_ctl.row_en[2] = (row_reg <= ROW_W'(HEIGHT));
                res_ctl.col_en    = 3'b011;
                res_ctl.row       = POS_W'(row_m2);
                res_ctl.col       = POS_W'(WIDTH - 1);
                res_ctl.last      = (row_reg == ROW_W'(HEIGHT + 1));
            end
        end
        else if (row_reg >= ROW_W'(1) && row_reg <= ROW_W'(HEIGHT))
        begin
            res_hit           = 1'b1;
            res_ctl.row_en[0] = (row_reg != ROW_W'(1));
            res_ctl.row_en[1] = 1'b1;
            res_ctl.row_en[2] = (row_reg < ROW_W'(HEIGHT));
            res_ctl.col_en[0] = (col_reg != COL_W'(1));
            res_ctl.col_en[1] = 1'b1;
            res_ctl.col_en[2] = 1'b1;
            res_ctl.row       = POS_W'(row_m1);
            res_ctl.col       = POS_W'(col_m1);
        end
    end

    // line store chains
    assign new_pix = (row_reg < ROW_W'(HEIGHT)) ? pix_t'(s_axis_tdata[PIX_W-1:0]) : '0;

    genvar gi, gr, gc;
    generate
        for (gi = 0; gi < WIDTH; gi++)
        begin : g_line
            if (gi == 0)
            begin : g_head
                mmf_cell u_mid (.clk(clk), .en(in_acc), .d(new_pix), .q(mid_q[gi]));
                mmf_cell u_up  (.clk(clk), .en(in_acc), .d(mid_q[WIDTH-1]), .q(up_q[gi]));
            end
            else
            begin : g_body
                mmf_cell u_mid (.clk(clk), .en(in_acc), .d(mid_q[gi-1]), .q(mid_q[gi]));
                mmf_cell u_up  (.clk(clk), .en(in_acc), .d(up_q[gi-1]), .q(up_q[gi]));
            end
        end
    endgenerate

    assign new_col[0] = up_q[WIDTH-1];
    assign new_col[1] = mid_q[WIDTH-1];
    assign new_col[2] = new_pix;

    // window chains, newest column at the right
    generate
        for (gr = 0; gr < 3; gr++)
        begin : g_wrow
            for (gc = 0; gc < 3; gc++)
            begin : g_wcol
                if (gc == 2)
                begin : g_new
                    mmf_cell u_win (.clk(clk), .en(in_acc), .d(new_col[gr]),
                                    .q(win_q[gr*3+gc]));
                end
                else
                begin : g_old
                    mmf_cell u_win (.clk(clk), .en(in_acc), .d(win_q[gr*3+gc+1]),
                                    .q(win_q[gr*3+gc]));
                end
            end
        end
    endgenerate

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                win_flat[r*3+c] = win_q[r*3+c];
                win_en[r*3+c]   = s1_ctl_reg.row_en[r] & s1_ctl_reg.col_en[c];
            end
        end
    end

    mmf_reduce u_reduce (
        .win   (win_flat),
        .en    (win_en),
        .mode  (mode_reg),
        .value (red_value)
    );

    // result pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= res_hit;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ctl_reg <= res_ctl;
        end
        if (advance && s1_valid_reg)
        begin
            out_ctl_reg   <= s1_ctl_reg;
            out_value_reg <= red_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_ctl_reg.col, out_ctl_reg.row, out_value_reg};
    assign m_axis_tlast  = out_ctl_reg.last;

`ifndef ASSERT_OFF
    a_window_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> $stable(win_flat))
        else $error("window moved under a pending result");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
        (out_ctl_reg.row == POS_W'(HEIGHT - 1) && out_ctl_reg.col == POS_W'(WIDTH - 1)))
        else $error("frame_last on wrong position");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(WIDTH - 1))
        else $error("column counter out of range");

    a_wrap_row: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg == ROW_W'(HEIGHT + 1)) |-> (col_reg == '0))
        else $error("final drain row has more than one item");
`endif

endmodule
